### hw/rtl/tcw_pkg.sv
// shared constants and register codes for the congestion window controller
package tcw_pkg;

    // field widths
    localparam int ACTION_W    = 1;
    localparam int WAVE_W      = 10;
    localparam int TIME_W      = 32;
    localparam int WIN_W       = 32;
    localparam int PKT_W       = 16;
    localparam int MODE_W      = 2;
    localparam int TIMEOUT_W   = 36;
    localparam int CNT_W       = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // fixed point
    localparam int              FRAC_BITS = 16;
    localparam logic [TIME_W-1:0] ONE_FX  = TIME_W'(1) << FRAC_BITS;
    localparam logic [TIME_W-1:0] MAX32   = '1;
    localparam logic [CNT_W-1:0]  COUNT_MAX = '1;

    // divider: dividend width and quotient bits retired per cycle
    localparam int DVD_W       = 44;
    localparam int DIGIT_BITS  = 4;

    // default number of wave slots per action
    localparam int WAVES_DEFAULT = 1024;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_SIZE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_THRESHOLD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WINDOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_THRESHOLD = 3'd4;

    // protocol modes
    localparam logic [MODE_W-1:0] MODE_TAHOE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RENO  = 2'd1;

    // event actions
    localparam logic ACT_RTT        = 1'b0;
    localparam logic ACT_CONGESTION = 1'b1;

    // reset values
    localparam logic [MODE_W-1:0] PROTOCOL_MODE_RESET = MODE_TAHOE;
    localparam logic [PKT_W-1:0]  PACKET_SIZE_RESET   = 16'd8192;
    localparam logic [WIN_W-1:0]  MIN_THRESHOLD_RESET = 32'd8192;
    localparam logic [WIN_W-1:0]  WINDOW_RESET        = 32'd8192;
    localparam logic [WIN_W-1:0]  THRESHOLD_RESET     = 32'd65536;

endpackage

### hw/rtl/tcp_congestion_window_control_top.sv
// congestion window controller for one flow, seen bitmaps held in block memory
// sequence: wave slot, seen memory read, evaluation, then for a new rtt sample the mean
//   division and update, then the timeout division (skipped while no sample is counted)
// one item at a time; the shared 4-bit-per-cycle divider (mean, timeout) sets the pace;
//   the next input is taken while a finished result waits
// reset: a pass after reset clears every slot of the seen memory, no input taken then
module tcp_congestion_window_control_top #(
    parameter int WAVES = tcw_pkg::WAVES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // event channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tcw_pkg::ACTION_W-1:0]      action,
    input  logic [tcw_pkg::WAVE_W-1:0]        wave,
    input  logic [tcw_pkg::TIME_W-1:0]        rtt_sample,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tcw_pkg::WIN_W-1:0]         window,
    output logic [tcw_pkg::WIN_W-1:0]         threshold,
    output logic                              in_slow_start,
    output logic [tcw_pkg::TIME_W-1:0]        mean_rtt,
    output logic [tcw_pkg::TIMEOUT_W-1:0]     timeout,
    output logic                              repeated,
    // configuration write port
    input  logic                              cfg_write,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tcw_pkg::*;

    // memory index and divider sizing
    localparam int IDX_W     = $clog2(WAVES);
    localparam int DIV_W     = CNT_W + 1;
    localparam int DIV_STEPS = DVD_W / DIGIT_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int PROD_W    = TIME_W + CNT_W;
    localparam int TQ_W      = TIME_W + 2;

    // wave modulo WAVES by reciprocal multiplication, exact for every wave number
    localparam int MOD_SH    = WAVE_W + $clog2(WAVES);
    localparam int RECIP_W   = WAVE_W + 2;
    localparam int MPROD_W   = WAVE_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MOD_RECIP =
        RECIP_W'(((64'd1 << MOD_SH) + 64'(WAVES) - 64'd1) / 64'(WAVES));
    // quotient times WAVES never exceeds the wave, so the low bits suffice
    localparam logic [WAVE_W-1:0]  MOD_DIV   = WAVE_W'(WAVES);

    // sequencer codes
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_CLEAR = 4'd0;   // clearing pass over the seen memory
    localparam logic [ST_W-1:0] S_IDLE  = 4'd1;   // waiting for an event transfer
    localparam logic [ST_W-1:0] S_MOD   = 4'd2;   // wave modulo WAVES into the memory index
    localparam logic [ST_W-1:0] S_READ  = 4'd3;   // seen memory read issued
    localparam logic [ST_W-1:0] S_EVAL  = 4'd4;   // seen bits back, write back, react
    localparam logic [ST_W-1:0] S_MUL   = 4'd5;   // mean*count landed, load mean division
    localparam logic [ST_W-1:0] S_MDIV  = 4'd6;   // mean division running
    localparam logic [ST_W-1:0] S_UPD   = 4'd7;   // commit mean, count and window growth
    localparam logic [ST_W-1:0] S_TLOAD = 4'd8;   // start timeout division
    localparam logic [ST_W-1:0] S_TDIV  = 4'd9;   // timeout division running
    localparam logic [ST_W-1:0] S_TFIN  = 4'd10;  // form the result

    // sequencer
    logic [ST_W-1:0]      state_reg, state_next;
    logic [IDX_W-1:0]     clr_cnt_reg;

    // configuration (initial window and threshold are reloaded as defaults by
    // every reset, so a written value never reaches the window)
    logic [MODE_W-1:0]    mode_reg;
    logic [PKT_W-1:0]     packet_reg;
    logic [WIN_W-1:0]     min_thr_reg;

    // flow state
    logic [WIN_W-1:0]     cwnd_reg;
    logic [WIN_W-1:0]     ssthresh_reg;
    logic                 slow_reg;
    logic [TIME_W-1:0]    mean_reg;
    logic [TIME_W-1:0]    last_reg;
    logic [CNT_W-1:0]     count_reg;

    // latched event and working registers
    logic                 act_reg;
    logic [WAVE_W-1:0]    wave_reg;
    logic [TIME_W-1:0]    rtt_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [1:0]           rd_reg;
    logic                 rep_reg;
    logic [PROD_W-1:0]    prod_reg;

    // shared divider
    logic [DVD_W-1:0]     div_dvd_reg;
    logic [DIV_W-1:0]     div_rem_reg;
    logic [DIV_W-1:0]     div_dsr_reg;
    logic [STEP_W-1:0]    div_cnt_reg;
    logic [DVD_W-1:0]     dvd_step;
    logic [DIV_W-1:0]     rem_step;

    // seen bitmaps, bit 0 for rtt samples, bit 1 for congestion signals
    logic [1:0]           seen_mem [WAVES];

    // result register
    logic                 out_valid_reg;
    logic [WIN_W-1:0]     out_window_reg;
    logic [WIN_W-1:0]     out_thr_reg;
    logic                 out_slow_reg;
    logic [TIME_W-1:0]    out_mean_reg;
    logic [TIMEOUT_W-1:0] out_tout_reg;
    logic                 out_rep_reg;

    // derived
    logic                 seen_bit;
    logic                 out_load;
    logic                 div_busy;
    logic [WIN_W:0]       win_double;
    logic [WIN_W:0]       win_add;
    logic [WIN_W-1:0]     win_half;
    logic [TQ_W-1:0]      tout_sum;
    logic [TIMEOUT_W-1:0] tout_val;
    logic [MPROD_W-1:0]   mod_prod;
    logic [WAVE_W-1:0]    mod_quot;
    logic [WAVE_W-1:0]    mod_rem;

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign window        = out_window_reg;
    assign threshold     = out_thr_reg;
    assign in_slow_start = out_slow_reg;
    assign mean_rtt      = out_mean_reg;
    assign timeout       = out_tout_reg;
    assign repeated      = out_rep_reg;

    assign seen_bit = (act_reg == ACT_CONGESTION) ? rd_reg[1] : rd_reg[0];
    assign out_load = (state_reg == S_TFIN) && (!out_valid_reg || out_ready);
    assign div_busy = (state_reg == S_MDIV) || (state_reg == S_TDIV);

    assign win_double = {cwnd_reg, 1'b0};
    assign win_add    = {1'b0, cwnd_reg} + (WIN_W + 1)'(packet_reg);
    assign win_half   = cwnd_reg >> 1;

    // wave slot: quotient from the reciprocal, remainder by subtraction
    assign mod_prod = MPROD_W'(wave_reg) * MPROD_W'(MOD_RECIP);
    assign mod_quot = WAVE_W'(mod_prod >> MOD_SH);
    assign mod_rem  = wave_reg - WAVE_W'(mod_quot * MOD_DIV);

    // timeout: mean plus 2*last/count, floored at one, times four; the sum stays
    // below 2^34 so the shifted value always fits the field
    assign tout_sum = TQ_W'(mean_reg) + div_dvd_reg[TQ_W-1:0];
    always_comb
    begin
        if (count_reg == '0)
        begin
            tout_val = TIMEOUT_W'(ONE_FX) << 2;
        end
        else if (tout_sum < TQ_W'(ONE_FX))
        begin
            tout_val = TIMEOUT_W'(ONE_FX) << 2;
        end
        else
        begin
            tout_val = {tout_sum, 2'b00};
        end
    end

    // restoring divider, DIGIT_BITS quotient bits per cycle on a narrow remainder
    always_comb
    begin
        logic [DIV_W:0] trial;
        rem_step = div_rem_reg;
        dvd_step = div_dvd_reg;
        trial    = '0;
        for (int i = 0; i < DIGIT_BITS; i++)
        begin
            trial    = {rem_step, dvd_step[DVD_W-1]};
            dvd_step = {dvd_step[DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, div_dsr_reg})
            begin
                rem_step    = DIV_W'(trial - {1'b0, div_dsr_reg});
                dvd_step[0] = 1'b1;
            end
            else
            begin
                rem_step = trial[DIV_W-1:0];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(WAVES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                // only a new rtt sample needs the mean division
                if (!seen_bit && act_reg == ACT_RTT)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_TLOAD;
                end
            end
            S_MUL:
            begin
                state_next = S_MDIV;
            end
            S_MDIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                state_next = S_TLOAD;
            end
            S_TLOAD:
            begin
                // no samples yet: the timeout is a constant, skip the division
                state_next = (count_reg == '0) ? S_TFIN : S_TDIV;
            end
            S_TDIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = S_TFIN;
                end
            end
            S_TFIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and flow state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            mode_reg      <= PROTOCOL_MODE_RESET;
            packet_reg    <= PACKET_SIZE_RESET;
            min_thr_reg   <= MIN_THRESHOLD_RESET;
            cwnd_reg      <= WINDOW_RESET;
            ssthresh_reg  <= THRESHOLD_RESET;
            slow_reg      <= 1'b1;
            mean_reg      <= '0;
            last_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_PROTOCOL_MODE: mode_reg    <= cfg_data[MODE_W-1:0];
                    REG_PACKET_SIZE:   packet_reg  <= cfg_data[PKT_W-1:0];
                    REG_MIN_THRESHOLD: min_thr_reg <= cfg_data[WIN_W-1:0];
                    REG_INITIAL_WINDOW, REG_INITIAL_THRESHOLD:
                    begin
                        // no effect: reset restores the defaults, so a written value is never used
                    end
                    default:
                    begin
                    end
                endcase
            end

            // congestion reaction, none in the no-reaction modes
            if (state_reg == S_EVAL && !seen_bit && act_reg == ACT_CONGESTION)
            begin
                if (mode_reg == MODE_TAHOE || mode_reg == MODE_RENO)
                begin
                    ssthresh_reg <= (win_half > min_thr_reg) ? win_half : min_thr_reg;
                    slow_reg     <= 1'b1;
                    if (mode_reg == MODE_TAHOE)
                    begin
                        cwnd_reg <= WIN_W'(packet_reg);
                    end
                    else
                    begin
                        cwnd_reg <= (win_half > WIN_W'(packet_reg)) ? win_half
                                                                    : WIN_W'(packet_reg);
                    end
                end
            end

            // new sample: mean, last, count and window growth
            if (state_reg == S_UPD)
            begin
                if (div_dvd_reg < DVD_W'(ONE_FX))
                begin
                    mean_reg <= ONE_FX;
                end
                else if (div_dvd_reg[DVD_W-1:TIME_W] != '0)
                begin
                    mean_reg <= MAX32;
                end
                else
                begin
                    mean_reg <= div_dvd_reg[TIME_W-1:0];
                end
                last_reg <= rtt_reg;
                if (count_reg != COUNT_MAX)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (slow_reg)
                begin
                    // exit test uses the full doubled value
                    if (win_double >= (WIN_W + 1)'(ssthresh_reg))
                    begin
                        slow_reg <= 1'b0;
                    end
                    cwnd_reg <= win_double[WIN_W] ? MAX32 : win_double[WIN_W-1:0];
                end
                else
                begin
                    cwnd_reg <= win_add[WIN_W] ? MAX32 : win_add[WIN_W-1:0];
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and divider registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg  <= action;
            wave_reg <= wave;
            rtt_reg  <= rtt_sample;
        end

        // divider load per phase, otherwise iterate while busy
        if (state_reg == S_MUL)
        begin
            div_dvd_reg <= DVD_W'(prod_reg) + DVD_W'(rtt_reg);
            div_rem_reg <= '0;
            div_dsr_reg <= DIV_W'(count_reg) + DIV_W'(1);
            div_cnt_reg <= STEP_W'(DIV_STEPS - 1);
        end
        else if (state_reg == S_TLOAD)
        begin
            div_dvd_reg <= DVD_W'({last_reg, 1'b0});
            div_rem_reg <= '0;
            div_dsr_reg <= DIV_W'(count_reg);
            div_cnt_reg <= STEP_W'(DIV_STEPS - 1);
        end
        else if (div_busy)
        begin
            div_dvd_reg <= dvd_step;
            div_rem_reg <= rem_step;
            div_cnt_reg <= div_cnt_reg - STEP_W'(1);
        end

        if (state_reg == S_MOD)
        begin
            idx_reg <= IDX_W'(mod_rem);
        end

        if (state_reg == S_EVAL)
        begin
            rep_reg  <= seen_bit;
            prod_reg <= PROD_W'(mean_reg) * PROD_W'(count_reg);
        end

        if (out_load)
        begin
            out_window_reg <= cwnd_reg;
            out_thr_reg    <= ssthresh_reg;
            out_slow_reg   <= slow_reg;
            out_mean_reg   <= mean_reg;
            out_tout_reg   <= tout_val;
            out_rep_reg    <= rep_reg;
        end
    end

    // seen memory: one write port (clearing pass or write back), one registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            seen_mem[clr_cnt_reg] <= 2'b00;
        end
        else if (state_reg == S_EVAL)
        begin
            seen_mem[idx_reg] <= (act_reg == ACT_CONGESTION) ? (rd_reg | 2'b10)
                                                             : (rd_reg | 2'b01);
        end

        if (state_reg == S_READ)
        begin
            rd_reg <= seen_mem[idx_reg];
        end
    end

    // a running division is never restarted or left early
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_busy && div_cnt_reg != '0) |=> (state_reg == $past(state_reg)))
        else $error("divider phase left before its last step");

    // the mean only moves when a new sample is committed
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(mean_reg) |-> ($past(state_reg) == S_UPD))
        else $error("mean changed outside a sample update");

    // once a sample is counted the mean is floored at one
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (mean_reg >= ONE_FX))
        else $error("mean below one with samples counted");

    // a result formed in the final phase is offered at the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("formed result not offered");

endmodule

### bench/tcp_congestion_window_control_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the congestion window controller, with its own flow model
module tcp_congestion_window_control_top_tb;
    import tcw_pkg::*;

    // clocking and run limits
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 800000;
    // longer than the slowest result takes from its input transfer, so wait well beyond
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_LIMIT = 10;
    localparam int FLOW_SLOTS   = WAVES_DEFAULT;

    // modes that the package leaves unnamed: both mean no congestion reaction
    localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam logic [63:0] TIMEOUT_CAP = 64'h0000_000F_FFFF_FFFF;

    typedef struct {
        logic [WIN_W-1:0]     window;
        logic [WIN_W-1:0]     threshold;
        logic                 slow;
        logic [TIME_W-1:0]    mean;
        logic [TIMEOUT_W-1:0] timeout;
        logic                 repeated;
    } flow_result_t;

    // dut connections
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [ACTION_W-1:0]   action;
    logic [WAVE_W-1:0]     wave;
    logic [TIME_W-1:0]     rtt_sample;
    logic                  out_valid;
    logic                  out_ready;
    logic [WIN_W-1:0]      window;
    logic [WIN_W-1:0]      threshold;
    logic                  in_slow_start;
    logic [TIME_W-1:0]     mean_rtt;
    logic [TIMEOUT_W-1:0]  timeout;
    logic                  repeated;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // bench control
    bit                    idle_on;
    int                    stall_left = 0;
    int                    cycle_count = 0;
    int                    mismatches = 0;
    flow_result_t          expected_results[$];

    // model copy of the registers
    logic [MODE_W-1:0]     cfg_mode;
    logic [PKT_W-1:0]      cfg_packet;
    logic [WIN_W-1:0]      cfg_min_thr;
    logic [WIN_W-1:0]      cfg_init_win;
    logic [WIN_W-1:0]      cfg_init_thr;

    // model copy of the flow state
    bit                    rtt_seen [FLOW_SLOTS];
    bit                    cong_seen [FLOW_SLOTS];
    logic [WIN_W-1:0]      flow_window;
    logic [WIN_W-1:0]      flow_threshold;
    logic                  flow_slow;
    logic [TIME_W-1:0]     flow_mean;
    logic [TIME_W-1:0]     flow_last;
    logic [CNT_W-1:0]      flow_count;

    tcp_congestion_window_control_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .wave          (wave),
        .rtt_sample    (rtt_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .window        (window),
        .threshold     (threshold),
        .in_slow_start (in_slow_start),
        .mean_rtt      (mean_rtt),
        .timeout       (timeout),
        .repeated      (repeated),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side back-pressure: random stall bursts while idling is on
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            out_ready = 1'b0;
            stall_left = $urandom_range(0, 5);
        end
        else
            out_ready = 1'b1;
    end

    // ------------------------------------------------------------------------
    // flow model
    // ------------------------------------------------------------------------

    // state after reset: registers at their reset values, bitmaps clear
    function automatic void restart_flow();
        cfg_mode     = PROTOCOL_MODE_RESET;
        cfg_packet   = PACKET_SIZE_RESET;
        cfg_min_thr  = MIN_THRESHOLD_RESET;
        cfg_init_win = WINDOW_RESET;
        cfg_init_thr = THRESHOLD_RESET;
        foreach (rtt_seen[i])
            rtt_seen[i] = 1'b0;
        foreach (cong_seen[i])
            cong_seen[i] = 1'b0;
        flow_window    = cfg_init_win;
        flow_threshold = cfg_init_thr;
        flow_slow      = 1'b1;
        flow_mean      = '0;
        flow_last      = '0;
        flow_count     = '0;
    endfunction

    // applies one event to the model and returns the result the block should report
    function automatic flow_result_t advance_flow(logic act, logic [WAVE_W-1:0] wv,
                                                  logic [TIME_W-1:0] rtt);
        flow_result_t     r;
        int               slot;
        logic             rep;
        logic [63:0]      m;
        logic [63:0]      grown;
        logic [63:0]      t;
        logic [WIN_W-1:0] half;
        logic [WIN_W-1:0] step;
        slot = int'(wv) % FLOW_SLOTS;
        rep  = (act == ACT_CONGESTION) ? cong_seen[slot] : rtt_seen[slot];
        step = WIN_W'(cfg_packet);
        if (!rep)
        begin
            if (act == ACT_CONGESTION)
            begin
                cong_seen[slot] = 1'b1;
                half = flow_window >> 1;
                // only tahoe and reno react, the two other codes just mark the wave
                if (cfg_mode == MODE_TAHOE || cfg_mode == MODE_RENO)
                begin
                    flow_threshold = (half > cfg_min_thr) ? half : cfg_min_thr;
                    if (cfg_mode == MODE_TAHOE)
                        flow_window = step;
                    else
                        flow_window = (half > step) ? half : step;
                    flow_slow = 1'b1;
                end
            end
            else
            begin
                rtt_seen[slot] = 1'b1;
                // running mean over the old count, floored at one time unit
                m = (64'(flow_mean) * 64'(flow_count) + 64'(rtt)) / (64'(flow_count) + 64'd1);
                if (m < 64'(ONE_FX))
                    m = 64'(ONE_FX);
                if (m > 64'(MAX32))
                    m = 64'(MAX32);
                flow_mean = m[TIME_W-1:0];
                flow_last = rtt;
                if (flow_count != COUNT_MAX)
                    flow_count++;
                if (flow_slow)
                begin
                    // exit test uses the full doubled value, before saturation
                    grown = 64'(flow_window) * 64'd2;
                    if (grown >= 64'(flow_threshold))
                        flow_slow = 1'b0;
                end
                else
                    grown = 64'(flow_window) + 64'(step);
                flow_window = (grown > 64'(MAX32)) ? MAX32 : grown[WIN_W-1:0];
            end
        end
        if (flow_count == '0)
            t = 64'(ONE_FX) * 64'd4;
        else
        begin
            t = 64'(flow_mean) + (64'(flow_last) * 64'd2) / 64'(flow_count);
            if (t < 64'(ONE_FX))
                t = 64'(ONE_FX);
            t = t * 64'd4;
            if (t > TIMEOUT_CAP)
                t = TIMEOUT_CAP;
        end
        r.window    = flow_window;
        r.threshold = flow_threshold;
        r.slow      = flow_slow;
        r.mean      = flow_mean;
        r.timeout   = t[TIMEOUT_W-1:0];
        r.repeated  = rep;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endfunction

    // every result transfer is matched against the oldest outstanding prediction
    always @(posedge clk)
    begin
        flow_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result with nothing outstanding: window %h threshold %h",
                             window, threshold);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("window", 64'(want.window), 64'(window));
                check_field("threshold", 64'(want.threshold), 64'(threshold));
                check_field("in_slow_start", 64'(want.slow), 64'(in_slow_start));
                check_field("mean_rtt", 64'(want.mean), 64'(mean_rtt));
                check_field("timeout", 64'(want.timeout), 64'(timeout));
                check_field("repeated", 64'(want.repeated), 64'(repeated));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one event transfer; valid is left high so a back-to-back event needs no gap
    task automatic send_event(logic act, logic [WAVE_W-1:0] wv, logic [TIME_W-1:0] rtt);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        action     = act;
        wave       = wv;
        rtt_sample = rtt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(advance_flow(act, wv, rtt));
    endtask

    // drop valid and wait until every outstanding result has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_PROTOCOL_MODE:     cfg_mode     = data[MODE_W-1:0];
            REG_PACKET_SIZE:       cfg_packet   = data[PKT_W-1:0];
            REG_MIN_THRESHOLD:     cfg_min_thr  = data;
            // reload values never reach the flow, reset restores defaults, so the live window stays as it is
            REG_INITIAL_WINDOW:    cfg_init_win = data;
            REG_INITIAL_THRESHOLD: cfg_init_thr = data;
            default: ;
        endcase
    endtask

    task automatic set_flow_config(logic [MODE_W-1:0] mode, logic [PKT_W-1:0] pkt,
                                   logic [WIN_W-1:0] min_thr);
        write_reg(REG_PROTOCOL_MODE, CFG_DATA_W'(mode));
        write_reg(REG_PACKET_SIZE, CFG_DATA_W'(pkt));
        write_reg(REG_MIN_THRESHOLD, min_thr);
    endtask

    function automatic logic [TIME_W-1:0] random_rtt();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return MAX32;
            2: return ONE_FX;
            3, 4, 5, 6: return $urandom_range(0, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PKT_W-1:0] random_packet();
        case ($urandom_range(0, 4))
            0: return 16'd1;
            1: return 16'hFFFF;
            2: return PKT_W'($urandom_range(1, 64));
            default: return PKT_W'($urandom_range(1, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [WIN_W-1:0] random_min_threshold();
        case ($urandom_range(0, 3))
            0: return 32'd1;
            1: return MAX32;
            2: return $urandom_range(1, 32'h0010_0000);
            default: return $urandom_range(32'hFFFF_FFFF, 1);
        endcase
    endfunction

    // mostly a wave not yet seen for this action, sometimes any wave at all
    function automatic logic [WAVE_W-1:0] pick_wave(logic act);
        logic [WAVE_W-1:0] w;
        if ($urandom_range(0, 99) < 85)
        begin
            repeat (64)
            begin
                w = WAVE_W'($urandom_range(0, FLOW_SLOTS - 1));
                if (act == ACT_CONGESTION ? !cong_seen[w] : !rtt_seen[w])
                    return w;
            end
        end
        return WAVE_W'($urandom);
    endfunction

    // well-formed bursts: a congestion signal and then a run of samples, with stray events
    task automatic run_traffic(int n_items);
        int sent;
        int run;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                send_event(1'($urandom_range(0, 1)), WAVE_W'($urandom), random_rtt());
                sent++;
            end
            send_event(ACT_CONGESTION, pick_wave(ACT_CONGESTION), random_rtt());
            sent++;
            run = $urandom_range(1, 8);
            repeat (run)
            begin
                send_event(ACT_RTT, pick_wave(ACT_RTT), random_rtt());
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset register values: congestion before any sample, mean floor, repeats, extremes
    task automatic test_reset_defaults();
        send_event(ACT_CONGESTION, 10'd5, '0);
        send_event(ACT_RTT, 10'd0, '0);
        send_event(ACT_RTT, 10'd0, 32'h1234_5678);
        send_event(ACT_RTT, 10'd1023, MAX32);
        send_event(ACT_RTT, 10'd512, ONE_FX);
        send_event(ACT_CONGESTION, 10'd5, MAX32);
        send_event(ACT_CONGESTION, 10'd1023, '0);
        send_event(ACT_RTT, 10'd1, 32'h0000_8000);
        wait_drained();
    endtask

    // reno halving with the threshold floor at its lowest and the packet floor at its top
    task automatic test_reno_halving();
        set_flow_config(MODE_RENO, 16'hFFFF, 32'd1);
        send_event(ACT_RTT, 10'd2, 32'h0003_0000);
        send_event(ACT_RTT, 10'd3, 32'h0000_4000);
        send_event(ACT_CONGESTION, 10'd1, '0);
        send_event(ACT_CONGESTION, 10'd2, '0);
        wait_drained();
    endtask

    // both codes without congestion reaction: the signal only marks its wave
    task automatic test_no_reaction();
        set_flow_config(MODE_HOLD, 16'd8192, 32'd8192);
        send_event(ACT_CONGESTION, 10'd700, '0);
        send_event(ACT_RTT, 10'd700, MAX32);
        wait_drained();
        write_reg(REG_PROTOCOL_MODE, CFG_DATA_W'(MODE_SPARE));
        send_event(ACT_CONGESTION, 10'd701, '0);
        wait_drained();
    endtask

    // packet size one and the threshold floor at its top; reload registers must not touch the flow
    task automatic test_small_packet();
        set_flow_config(MODE_TAHOE, 16'd1, MAX32);
        write_reg(REG_INITIAL_WINDOW, 32'd1);
        write_reg(REG_INITIAL_THRESHOLD, MAX32);
        send_event(ACT_CONGESTION, 10'd3, '0);
        send_event(ACT_RTT, 10'd4, 32'd1);
        send_event(ACT_RTT, 10'd5, 32'h0002_0000);
        send_event(ACT_RTT, 10'd6, 32'h8000_0000);
        wait_drained();
        write_reg(REG_INITIAL_WINDOW, MAX32);
        write_reg(REG_INITIAL_THRESHOLD, 32'd1);
        send_event(ACT_RTT, 10'd7, 32'h0001_8000);
        wait_drained();
    endtask

    // several register settings, each phase separated by a full drain
    task automatic test_random_traffic();
        set_flow_config(MODE_TAHOE, random_packet(), random_min_threshold());
        run_traffic(170);
        wait_drained();
        // reno with an unbounded floor leaves the threshold at its top value
        set_flow_config(MODE_RENO, 16'hFFFF, MAX32);
        run_traffic(170);
        wait_drained();
        // no reaction in this phase, so slow start doubles on until the window saturates
        set_flow_config(MODE_HOLD, 16'hFFFF, MAX32);
        run_traffic(170);
        wait_drained();
        set_flow_config(MODE_SPARE, 16'd1, random_min_threshold());
        run_traffic(170);
        wait_drained();
        set_flow_config(MODE_RENO, random_packet(), 32'd1);
        run_traffic(170);
        wait_drained();
        set_flow_config(MODE_TAHOE, random_packet(), random_min_threshold());
        write_reg(REG_INITIAL_WINDOW, $urandom);
        write_reg(REG_INITIAL_THRESHOLD, $urandom);
        run_traffic(170);
        wait_drained();
        set_flow_config(MODE_W'($urandom_range(0, 3)), random_packet(),
                        random_min_threshold());
        run_traffic(170);
        wait_drained();
    endtask

    // closing stretch with no idling on either side
    task automatic test_steady_stream();
        idle_on = 1'b0;
        set_flow_config(MODE_W'($urandom_range(0, 1)), random_packet(),
                        random_min_threshold());
        run_traffic(280);
        wait_drained();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = '0;
        wave       = '0;
        rtt_sample = '0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        out_ready  = 1'b0;
        idle_on    = 1'b1;
        restart_flow();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // the bitmap clearing pass after reset simply holds off the first transfer
        test_reset_defaults();
        test_reno_halving();
        test_no_reaction();
        test_small_packet();
        test_random_traffic();
        test_steady_stream();

        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
